// ----- src/bsac_pkg.sv -----
// ----------------------------------------------------------------------------
// Structural alphabet classifier package
// Shared constants and the descriptor table of the 27 letter classifier.
// ----------------------------------------------------------------------------
package bsac_pkg;

  localparam int MaxResidues = 4096;
  localparam int NumLetters  = 27;
  localparam int ScaleLimit  = 32767;
  localparam int NumFeatures = 4;

  // Descriptor vectors in Q8, rounded to nearest from hundredths of an angstrom.
  localparam logic signed [12:0] DescQ8 [NumLetters][NumFeatures] = '{
    '{13'sd1380, 13'sd1303, 13'sd1377, 13'sd748},
    '{13'sd1390, 13'sd1303, 13'sd1388, 13'sd753},
    '{13'sd1385, 13'sd1339, 13'sd1436, 13'sd732},
    '{13'sd1439, 13'sd1344, 13'sd1388, 13'sd735},
    '{13'sd1431, 13'sd1405, 13'sd1480, 13'sd660},
    '{13'sd1382, 13'sd1428, 13'sd1388, 13'sd868},
    '{13'sd1480, 13'sd1454, 13'sd1554, 13'sd374},
    '{13'sd1421, 13'sd1981, 13'sd1434, -13'sd847},
    '{13'sd1434, 13'sd1718, 13'sd1408, 13'sd945},
    '{13'sd1457, 13'sd2071, 13'sd1452, 13'sd791},
    '{13'sd1449, 13'sd2291, 13'sd1674, 13'sd535},
    '{13'sd1449, 13'sd2281, 13'sd1705, -13'sd374},
    '{13'sd1449, 13'sd2066, 13'sd1715, 13'sd758},
    '{13'sd1459, 13'sd1859, 13'sd1797, 13'sd225},
    '{13'sd1544, 13'sd1754, 13'sd1444, -13'sd161},
    '{13'sd1656, 13'sd1516, 13'sd1423, 13'sd136},
    '{13'sd1682, 13'sd2294, 13'sd1428, -13'sd561},
    '{13'sd1718, 13'sd2117, 13'sd1400, -13'sd911},
    '{13'sd1590, 13'sd2358, 13'sd1477, 13'sd69},
    '{13'sd1759, 13'sd2120, 13'sd1544, -13'sd881},
    '{13'sd1764, 13'sd2289, 13'sd1731, -13'sd123},
    '{13'sd1720, 13'sd2335, 13'sd1641, -13'sd847},
    '{13'sd1718, 13'sd2468, 13'sd1664, -13'sd666},
    '{13'sd1636, 13'sd2542, 13'sd1728, -13'sd274},
    '{13'sd1759, 13'sd2575, 13'sd1667, -13'sd361},
    '{13'sd1659, 13'sd2604, 13'sd1815, 13'sd169},
    '{13'sd1741, 13'sd2650, 13'sd1754, -13'sd64}
  };

endpackage

// ----- src/backbone_structural_alphabet_classifier.sv -----
// ----------------------------------------------------------------------------
// Backbone structural alphabet classifier
// Assigns one of 27 structural letters to residue i-2 from four C-alpha
// positions, using one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  in      | in_valid_i, in_stall_o | chain_start_i, present_i, pos_x/y/z_i
//  out     | out_valid_o, out_stall_i | letter_o, residue_index_o
//
//  An item that yields no letter is taken and leaves the sequencer idle.
//  An item that yields a letter keeps the input stalled until its result is
//  loaded; zero to nine normalizing shifts vary its time, and a degenerate plane
//  cuts it short. The shared 32 x 32 multiplier and the one-bit-per-cycle square
//  root and divider set its pace, the 108 score products the most.
//  Reset clears the window, the residue counter and the sequencer.
//  A stalled result holds the sequencer in its final step; new items wait.
module backbone_structural_alphabet_classifier import bsac_pkg::*; #(
  parameter int MAX_RESIDUES = MaxResidues
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               chain_start_i,
  input  logic               present_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [23:0] pos_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         letter_o,
  output logic [11:0]        residue_index_o
);

  localparam int CntW = $clog2(MAX_RESIDUES);
  localparam int IdxW = (CntW > 12) ? CntW : 12;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDist  = 4'd1;
  localparam logic [3:0] StDsqrt = 4'd2;
  localparam logic [3:0] StMax   = 4'd3;
  localparam logic [3:0] StNorm  = 4'd4;
  localparam logic [3:0] StCross = 4'd5;
  localparam logic [3:0] StNn    = 4'd6;
  localparam logic [3:0] StNsqrt = 4'd7;
  localparam logic [3:0] StDot   = 4'd8;
  localparam logic [3:0] StDiv   = 4'd9;
  localparam logic [3:0] StScore = 4'd10;
  localparam logic [3:0] StDone  = 4'd11;

  localparam logic [1:0] DistP [3] = '{2'd0, 2'd0, 2'd1};
  localparam logic [1:0] DistQ [3] = '{2'd2, 2'd3, 2'd3};
  localparam logic [1:0] VecPt [9] = '{2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3};
  localparam logic [1:0] VecCo [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
  localparam logic [3:0] CrossA [6] = '{4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd1};
  localparam logic [3:0] CrossB [6] = '{4'd5, 4'd4, 4'd3, 4'd5, 4'd4, 4'd3};

  function automatic logic [27:0] mag28(input logic signed [27:0] v);
    return v[27] ? 28'(-v) : 28'(v);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  logic [3:0]        state_q;
  logic [4:0]        k_q;
  logic [4:0]        j_q;
  logic [1:0]        fi_q;
  logic              ph_q;
  logic signed [23:0] wp_q [3][3];
  logic              wpres_q [3];
  logic [CntW-1:0]   cnt_q;
  logic signed [23:0] pt_q [4][3];
  logic [11:0]       ridx_q;
  logic [63:0]       prod_q;
  logic              neg_q;
  logic signed [64:0] acc_q;
  logic [63:0]       sx_q;
  logic [63:0]       sr_q;
  logic signed [26:0] f_q [4];
  logic [24:0]       vm_q [9];
  logic              vs_q [9];
  logic [24:0]       mx_q;
  logic [3:0]        s_q;
  logic signed [31:0] n_q [3];
  logic [31:0]       den_q;
  logic              dneg_q;
  logic [15:0]       qt_q;
  logic [56:0]       best_q;
  logic [4:0]        bestj_q;
  logic              out_valid_q;
  logic [4:0]        letter_q;
  logic [11:0]       ridx_out_q;

  logic              in_acc;
  logic              emit;
  logic [CntW-1:0]   cur;
  logic [IdxW-1:0]   cur_ext;
  logic signed [23:0] in_pos [3];
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic              mul_neg;
  logic [63:0]       mul_p;
  logic signed [64:0] acc_nx;
  logic [63:0]       sq_bit;
  logic [63:0]       sq_try;
  logic              sq_ge;
  logic [63:0]       sr_nx;
  logic              dv_ge;
  logic signed [24:0] vdiff;
  logic signed [27:0] sdiff;
  logic [48:0]       dmag;
  logic [16:0]       qv;
  logic [25:0]       fm;
  logic              out_load;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign emit       = present_i && !chain_start_i && wpres_q[0] && wpres_q[1] && wpres_q[2];
  assign cur        = chain_start_i ? '0 : cnt_q;
  assign cur_ext    = IdxW'(cur);
  assign in_pos[0]  = pos_x_i;
  assign in_pos[1]  = pos_y_i;
  assign in_pos[2]  = pos_z_i;

  assign vdiff = 25'(pt_q[VecPt[k_q[3:0]]][VecCo[k_q[3:0]]]) - 25'(pt_q[0][VecCo[k_q[3:0]]]);
  assign sdiff = 28'(f_q[k_q[1:0]]) - 28'(DescQ8[j_q][k_q[1:0]]);

  always_comb begin
    logic signed [24:0] dd;
    dd      = 25'(pt_q[DistP[fi_q]][k_q[1:0]]) - 25'(pt_q[DistQ[fi_q]][k_q[1:0]]);
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state_q)
      StDist: begin
        mul_a = 32'(mag28(28'(dd)));
        mul_b = 32'(mag28(28'(dd)));
      end
      StCross: begin
        mul_a   = 32'(vm_q[CrossA[k_q[2:0]]][14:0]);
        mul_b   = 32'(vm_q[CrossB[k_q[2:0]]][14:0]);
        mul_neg = vs_q[CrossA[k_q[2:0]]] ^ vs_q[CrossB[k_q[2:0]]] ^ k_q[0];
      end
      StNn: begin
        mul_a = mag32(n_q[k_q[1:0]]);
        mul_b = mag32(n_q[k_q[1:0]]);
      end
      StDot: begin
        mul_a   = mag32(n_q[k_q[1:0]]);
        mul_b   = 32'(vm_q[4'd6 + {2'b00, k_q[1:0]}][14:0]);
        mul_neg = n_q[k_q[1:0]][31] ^ vs_q[4'd6 + {2'b00, k_q[1:0]}];
      end
      StScore: begin
        mul_a = 32'(mag28(sdiff));
        mul_b = 32'(mag28(sdiff));
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign acc_nx = acc_q + (neg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q}));

  assign sq_bit = 64'd1 << {k_q, 1'b0};
  assign sq_try = sr_q + sq_bit;
  assign sq_ge  = (sx_q >= sq_try);
  assign sr_nx  = sq_ge ? ((sr_q >> 1) + sq_bit) : (sr_q >> 1);
  assign dv_ge  = (sx_q >= sr_q);
  assign dmag   = acc_nx[64] ? 49'(-acc_nx) : 49'(acc_nx);
  assign qv     = {qt_q, dv_ge};
  assign fm     = 26'(qv) << s_q;
  assign out_load = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      k_q         <= '0;
      j_q         <= '0;
      fi_q        <= '0;
      ph_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        wpres_q[r] <= 1'b0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            wpres_q[0] <= !chain_start_i && wpres_q[1];
            wpres_q[1] <= !chain_start_i && wpres_q[2];
            wpres_q[2] <= present_i;
            cnt_q <= (cur < CntW'(MAX_RESIDUES - 1)) ? cur + 1'b1 : cur;
            if (emit) begin
              state_q <= StDist;
              k_q     <= '0;
              fi_q    <= '0;
              ph_q    <= 1'b0;
            end
          end
        end
        StDist, StNn, StDot, StCross, StScore: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            k_q <= k_q + 1'b1;
            if (state_q == StDist && k_q == 5'd2) begin
              state_q <= StDsqrt;
              k_q     <= 5'd31;
            end
            if (state_q == StCross && k_q == 5'd5) begin
              state_q <= StNn;
              k_q     <= '0;
            end
            if (state_q == StNn && k_q == 5'd2) begin
              k_q <= 5'd31;
              if (acc_nx == '0) begin
                state_q <= StDone;
              end else begin
                state_q <= StNsqrt;
              end
            end
            if (state_q == StDot && k_q == 5'd2) begin
              state_q <= StDiv;
              k_q     <= 5'd16;
            end
            if (state_q == StScore && k_q == 5'd3) begin
              k_q <= '0;
              j_q <= j_q + 1'b1;
              if (j_q == 5'(NumLetters - 1)) begin
                state_q <= StDone;
              end
            end
          end
        end
        StDsqrt: begin
          k_q <= k_q - 1'b1;
          if (k_q == '0) begin
            k_q  <= '0;
            fi_q <= fi_q + 1'b1;
            if (fi_q == 2'd2) begin
              state_q <= StMax;
            end else begin
              state_q <= StDist;
            end
          end
        end
        StMax: begin
          k_q <= k_q + 1'b1;
          if (k_q == 5'd8) begin
            state_q <= StNorm;
          end
        end
        StNorm: begin
          if (mx_q <= 25'(ScaleLimit)) begin
            state_q <= StCross;
            k_q     <= '0;
            ph_q    <= 1'b0;
          end
        end
        StNsqrt: begin
          k_q <= k_q - 1'b1;
          if (k_q == '0) begin
            state_q <= StDot;
            k_q     <= '0;
            ph_q    <= 1'b0;
          end
        end
        StDiv: begin
          k_q <= k_q - 1'b1;
          if (k_q == '0) begin
            state_q <= StScore;
            k_q     <= '0;
            j_q     <= '0;
            ph_q    <= 1'b0;
          end
        end
        StDone: begin
          if (out_load) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && state_q == StIdle) begin
      for (int c = 0; c < 3; c++) begin
        wp_q[0][c]    <= chain_start_i ? '0 : wp_q[1][c];
        wp_q[1][c]    <= chain_start_i ? '0 : wp_q[2][c];
        wp_q[2][c]    <= present_i ? in_pos[c] : '0;
        pt_q[0][c]    <= wp_q[0][c];
        pt_q[1][c]    <= wp_q[1][c];
        pt_q[2][c]    <= wp_q[2][c];
        pt_q[3][c]    <= in_pos[c];
      end
      ridx_q <= 12'(cur_ext - IdxW'(2));
      acc_q  <= '0;
    end
    prod_q <= mul_p;
    neg_q  <= mul_neg;
    case (state_q)
      StDist, StCross, StNn, StDot, StScore: begin
        if (ph_q) begin
          acc_q <= acc_nx;
          if (state_q == StDist && k_q == 5'd2) begin
            sx_q  <= acc_nx[63:0];
            sr_q  <= '0;
            acc_q <= '0;
          end
          if (state_q == StCross && k_q[0]) begin
            n_q[k_q[2:1]] <= acc_nx[31:0];
            acc_q         <= '0;
          end
          if (state_q == StNn && k_q == 5'd2) begin
            sx_q    <= acc_nx[63:0];
            sr_q    <= '0;
            acc_q   <= '0;
            bestj_q <= '0;
          end
          if (state_q == StDot && k_q == 5'd2) begin
            dneg_q <= acc_nx[64];
            sx_q   <= (64'(dmag) << 1) + 64'(den_q);
            sr_q   <= 64'(den_q) << 17;
            qt_q   <= '0;
          end
          if (state_q == StScore && k_q == 5'd3) begin
            acc_q <= '0;
            if (j_q == '0 || acc_nx[56:0] < best_q) begin
              best_q  <= acc_nx[56:0];
              bestj_q <= j_q;
            end
          end
        end
      end
      StDsqrt, StNsqrt: begin
        if (sq_ge) begin
          sx_q <= sx_q - sq_try;
        end
        sr_q <= sr_nx;
        if (k_q == '0) begin
          if (state_q == StDsqrt) begin
            f_q[fi_q] <= {1'b0, sr_nx[25:0]};
            mx_q      <= '0;
            s_q       <= '0;
          end else begin
            den_q <= sr_nx[31:0];
          end
        end
      end
      StMax: begin
        vm_q[k_q[3:0]] <= 25'(mag28(28'(vdiff)));
        vs_q[k_q[3:0]] <= vdiff[24];
        if (25'(mag28(28'(vdiff))) > mx_q) begin
          mx_q <= 25'(mag28(28'(vdiff)));
        end
      end
      StNorm: begin
        if (mx_q > 25'(ScaleLimit)) begin
          mx_q <= mx_q >> 1;
          s_q  <= s_q + 1'b1;
          for (int m = 0; m < 9; m++) begin
            vm_q[m] <= vm_q[m] >> 1;
          end
        end
      end
      StDiv: begin
        if (dv_ge) begin
          sx_q <= sx_q - sr_q;
        end
        sr_q <= sr_q >> 1;
        qt_q <= qv[15:0];
        if (k_q == '0) begin
          f_q[3] <= dneg_q ? -27'(fm) : 27'(fm);
          acc_q  <= '0;
        end
      end
      StDone: begin
        if (out_load) begin
          letter_q   <= bestj_q;
          ridx_out_q <= ridx_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign letter_o        = letter_q;
  assign residue_index_o = ridx_out_q;

endmodule

// ----- src/bsac_checker.sv -----
// ----------------------------------------------------------------------------
// Structural alphabet classifier checker
// Port-level assertions on the classifier, attached by a bind statement.
// ----------------------------------------------------------------------------
module bsac_checker import bsac_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               chain_start_i,
  input logic               present_i,
  input logic signed [23:0] pos_x_i,
  input logic signed [23:0] pos_y_i,
  input logic signed [23:0] pos_z_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [4:0]         letter_o,
  input logic [11:0]        residue_index_o
);

  // A letter always names one of the descriptors.
  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (letter_o < 5'(NumLetters)))
    else $error("letter out of range");

  // A new result only appears after the sequencer has been busy.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without prior work");

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(letter_o) && $stable(residue_index_o)))
    else $error("stalled result changed");

endmodule

bind backbone_structural_alphabet_classifier bsac_checker u_bsac_checker (.*);
